// ===== design/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  localparam logic [2:0] PH_PLAIN   = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_HEX_HI  = 3'd2;
  localparam logic [2:0] PH_WANT_BS = 3'd3;
  localparam logic [2:0] PH_WANT_U  = 3'd4;
  localparam logic [2:0] PH_HEX_LO  = 3'd5;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_ESCAPE    = 3'd1;
  localparam logic [2:0] ERR_HEX       = 3'd2;
  localparam logic [2:0] ERR_SURROGATE = 3'd3;
  localparam logic [2:0] ERR_NUL       = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [15:0] SURR_LO_TOP  = 16'hDFFF;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [2:0] count;
    byte_t [3:0] bytes;
    logic       byte_valid;
    logic       end_of_string;
    logic [2:0] error_code;
  } result_t;

endpackage

// ===== design/json_string_unescape_utf8_core.sv =====
// JSON string body unescaper that turns escapes into UTF-8 bytes.
//
// Bytes of a JSON string body, starting after the opening quote, enter on the
// input channel (in_valid, in_stall, in_byte), one item per cycle. Each input
// item yields zero to four result items on the output channel (out_valid,
// out_stall and the result fields); last marks the final result of an input.
// The state update is done in the cycle an item is accepted and its results
// are loaded into a four-entry result register, so the first result shows in
// the next cycle. Results leave one per cycle while out_stall is low; the input
// is stalled only while more than one result of the previous item is waiting,
// or while the final one is held by out_stall. Bytes that cause a single result
// stream at one item per cycle; a byte ending an escape with several UTF-8
// bytes holds the input until all but the last have left. A closing quote
// gives an end result and an error gives one error result; both return the
// parser to the plain phase. allow_nul is written through cfg_wr_en and
// cfg_wr_data by the user only while idle; the block does not enforce it.
// Synchronous reset clears parser state and allow_nul, drops pending results.
module json_string_unescape_utf8_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       end_of_string,
  output logic [2:0] error_code,
  output logic       last
);

  logic       allow_nul;
  logic [2:0] phase;
  logic [1:0] digit_count;
  logic [15:0] code_accum;
  logic [9:0] high_half;

  logic [2:0] phase_next;
  logic [1:0] digit_count_next;
  logic [15:0] code_accum_next;
  logic [9:0] high_half_next;
  jsu_pkg::result_t step;

  jsu_pkg::byte_t [3:0] res_bytes;
  logic [2:0] res_count;
  logic       res_bv;
  logic       res_eos;
  logic [2:0] res_err;

  logic accept;
  logic take;

  assign out_valid     = (res_count != 3'd0);
  assign take          = out_valid && !out_stall;
  assign in_stall      = !((res_count == 3'd0) || ((res_count == 3'd1) && !out_stall));
  assign accept        = in_valid && !in_stall;
  assign out_byte      = res_bytes[0];
  assign byte_valid    = res_bv;
  assign end_of_string = res_eos;
  assign error_code    = res_err;
  assign last          = (res_count == 3'd1);

  always_comb begin
    logic       hex_ok;
    logic [3:0] hex_val;
    logic [15:0] acc;
    logic [20:0] cp;
    logic       emit;
    jsu_pkg::result_t r;

    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
    acc  = {code_accum[11:0], hex_val};
    cp   = {5'd0, acc};
    emit = 1'b0;

    r                 = '0;
    phase_next        = phase;
    digit_count_next  = digit_count;
    code_accum_next   = code_accum;
    high_half_next    = high_half;

    case (phase)
      jsu_pkg::PH_ESC: begin
        phase_next = jsu_pkg::PH_PLAIN;
        r.count = 3'd1;
        r.byte_valid = 1'b1;
        case (in_byte)
          jsu_pkg::CH_QUOTE: r.bytes[0] = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_SLASH: r.bytes[0] = jsu_pkg::CH_SLASH;
          jsu_pkg::CH_BSL:   r.bytes[0] = jsu_pkg::CH_BSL;
          jsu_pkg::CH_B:     r.bytes[0] = 8'h08;
          jsu_pkg::CH_F:     r.bytes[0] = 8'h0C;
          jsu_pkg::CH_N:     r.bytes[0] = 8'h0A;
          jsu_pkg::CH_R:     r.bytes[0] = 8'h0D;
          jsu_pkg::CH_T:     r.bytes[0] = 8'h09;
          jsu_pkg::CH_ZERO: begin
            r.bytes[0] = 8'h00;
            if (!allow_nul) begin
              r.byte_valid = 1'b0;
              r.error_code = jsu_pkg::ERR_NUL;
            end
          end
          jsu_pkg::CH_U: begin
            r.count = 3'd0;
            r.byte_valid = 1'b0;
            phase_next = jsu_pkg::PH_HEX_HI;
            digit_count_next = 2'd0;
            code_accum_next = 16'd0;
          end
          default: begin
            r.byte_valid = 1'b0;
            r.error_code = jsu_pkg::ERR_ESCAPE;
          end
        endcase
      end
      jsu_pkg::PH_HEX_HI, jsu_pkg::PH_HEX_LO: begin
        if (!hex_ok) begin
          r.count = 3'd1;
          r.error_code = jsu_pkg::ERR_HEX;
        end else if (digit_count != 2'd3) begin
          code_accum_next = acc;
          digit_count_next = digit_count + 2'd1;
        end else if (phase == jsu_pkg::PH_HEX_HI) begin
          if (acc >= jsu_pkg::SURR_LO_BASE && acc <= jsu_pkg::SURR_LO_TOP) begin
            r.count = 3'd1;
            r.error_code = jsu_pkg::ERR_SURROGATE;
          end else if (acc >= jsu_pkg::SURR_HI_BASE && acc < jsu_pkg::SURR_LO_BASE) begin
            high_half_next = acc[9:0];
            code_accum_next = 16'd0;
            digit_count_next = 2'd0;
            phase_next = jsu_pkg::PH_WANT_BS;
          end else begin
            emit = 1'b1;
          end
        end else begin
          if (acc < jsu_pkg::SURR_LO_BASE || acc > jsu_pkg::SURR_LO_TOP) begin
            r.count = 3'd1;
            r.error_code = jsu_pkg::ERR_SURROGATE;
          end else begin
            cp = {5'({1'b0, high_half[9:6]} + 5'd1), high_half[5:0], acc[9:0]};
            emit = 1'b1;
          end
        end
      end
      jsu_pkg::PH_WANT_BS: begin
        if (in_byte != jsu_pkg::CH_BSL) begin
          r.count = 3'd1;
          r.error_code = jsu_pkg::ERR_SURROGATE;
        end else begin
          phase_next = jsu_pkg::PH_WANT_U;
        end
      end
      jsu_pkg::PH_WANT_U: begin
        if (in_byte != jsu_pkg::CH_U) begin
          r.count = 3'd1;
          r.error_code = jsu_pkg::ERR_SURROGATE;
        end else begin
          phase_next = jsu_pkg::PH_HEX_LO;
          digit_count_next = 2'd0;
          code_accum_next = 16'd0;
        end
      end
      default: begin
        phase_next = jsu_pkg::PH_PLAIN;
        if (in_byte == jsu_pkg::CH_BSL) begin
          phase_next = jsu_pkg::PH_ESC;
        end else if (in_byte == jsu_pkg::CH_QUOTE) begin
          r.count = 3'd1;
          r.end_of_string = 1'b1;
          digit_count_next = 2'd0;
          code_accum_next = 16'd0;
          high_half_next = 10'd0;
        end else if (in_byte == 8'h00 && !allow_nul) begin
          r.count = 3'd1;
          r.error_code = jsu_pkg::ERR_NUL;
        end else begin
          r.count = 3'd1;
          r.byte_valid = 1'b1;
          r.bytes[0] = in_byte;
        end
      end
    endcase

    if (emit) begin
      r.byte_valid = 1'b1;
      if (cp < 21'h80) begin
        r.count = 3'd1;
        r.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
        r.count = 3'd2;
        r.bytes[0] = {3'b110, cp[10:6]};
        r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
        r.count = 3'd3;
        r.bytes[0] = {4'b1110, cp[15:12]};
        r.bytes[1] = {2'b10, cp[11:6]};
        r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
        r.count = 3'd4;
        r.bytes[0] = {5'b11110, cp[20:18]};
        r.bytes[1] = {2'b10, cp[17:12]};
        r.bytes[2] = {2'b10, cp[11:6]};
        r.bytes[3] = {2'b10, cp[5:0]};
      end
    end

    if (emit || r.error_code != jsu_pkg::ERR_NONE) begin
      phase_next = jsu_pkg::PH_PLAIN;
      digit_count_next = 2'd0;
      code_accum_next = 16'd0;
      high_half_next = 10'd0;
    end
    step = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_nul   <= 1'b0;
      phase       <= jsu_pkg::PH_PLAIN;
      digit_count <= 2'd0;
      code_accum  <= 16'd0;
      high_half   <= 10'd0;
      res_count   <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        allow_nul <= cfg_wr_data;
      end
      if (accept) begin
        phase       <= phase_next;
        digit_count <= digit_count_next;
        code_accum  <= code_accum_next;
        high_half   <= high_half_next;
      end
      if (accept && step.count != 3'd0) begin
        res_count <= step.count;
      end else if (take) begin
        res_count <= res_count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step.count != 3'd0) begin
      res_bytes <= step.bytes;
      res_bv    <= step.byte_valid;
      res_eos   <= step.end_of_string;
      res_err   <= step.error_code;
    end else if (take) begin
      res_bytes <= {8'h00, res_bytes[3:1]};
    end
  end

endmodule
